>>> hw/rtl/lfs_pkg.sv
// Shared types and constants of the line follower steering unit.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned SensorW   = 4;
  localparam int unsigned TargetW   = 20;
  localparam int unsigned TicksW    = 32;
  localparam int unsigned CrossW    = 5;
  localparam int unsigned NumW      = 26;
  localparam int unsigned QuotW     = 18;
  localparam int unsigned DivSteps  = 13;
  localparam int unsigned StepW     = 4;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 80;

  localparam logic [CrossW-1:0] CrossMax = 5'd31;
  localparam logic [7:0] RstRightAngle = 8'd80;
  localparam logic [7:0] RstLarge      = 8'd65;
  localparam logic [7:0] RstRecover    = 8'd40;
  localparam logic [7:0] RstSmall      = 8'd15;
  localparam logic [9:0] RstBase       = 10'd250;
  localparam logic [7:0] RstLimit      = 8'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRightAngle  = 3'd0,
    CfgLarge       = 3'd1,
    CfgRecover     = 3'd2,
    CfgSmall       = 3'd3,
    CfgBase        = 3'd4,
    CfgLimit       = 3'd5
  } lfs_cfg_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StHold
  } lfs_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic out_load;
  } lfs_cmd_t;

  typedef struct packed {
    logic out_free;
  } lfs_sts_t;

endpackage

>>> hw/rtl/lfs_ctrl.sv
// Sequencer of the line follower steering unit: accept, multiply, divide, output.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfs_pkg::lfs_sts_t sts_i,
  output lfs_pkg::lfs_cmd_t cmd_o
);
  import lfs_pkg::*;

  lfs_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic last_step;

  assign last_step = (step_q == StepW'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StMul;
      end
      StMul: begin
        state_d = StDiv;
        step_d  = '0;
      end
      StDiv: begin
        step_d = step_q + 1'b1;
        if (last_step) state_d = StHold;
      end
      StHold: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StMul:  cmd_o.mul = 1'b1;
      StDiv:  cmd_o.step = 1'b1;
      StHold: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> hw/rtl/lfs_dp.sv
// Datapath: tracking state, turn mapping, speed multiply, radix-4 divider, output word.
// Depends on lfs_pkg; driven by lfs_ctrl.
`timescale 1ns / 1ps

module lfs_dp #(
  parameter int unsigned ARM_DELAY_TICKS  = 800,
  parameter int unsigned CROSS_HOLD_TICKS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [lfs_pkg::SensorW-1:0]   sensor_bits_i,
  input  logic                          start_req_i,
  input  lfs_pkg::lfs_cmd_t             cmd_i,
  output lfs_pkg::lfs_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfs_pkg::OutDataW-1:0]  out_data_o
);
  import lfs_pkg::*;

  localparam int unsigned ArmW = $clog2(ARM_DELAY_TICKS + 1);
  localparam logic [ArmW-1:0]   ArmMax  = ArmW'(ARM_DELAY_TICKS);
  localparam logic [CrossW-1:0] HoldMax = CrossW'(CROSS_HOLD_TICKS);

  localparam logic [3:0] PatCross    = 4'd0;
  localparam logic [3:0] PatR1       = 4'd1;
  localparam logic [3:0] PatR2       = 4'd3;
  localparam logic [3:0] PatL1       = 4'd8;
  localparam logic [3:0] PatL2       = 4'd12;
  localparam logic [3:0] PatLargeR   = 4'd7;
  localparam logic [3:0] PatLargeL   = 4'd14;
  localparam logic [3:0] PatSmallR   = 4'd11;
  localparam logic [3:0] PatSmallL   = 4'd13;
  localparam logic [3:0] PatLost     = 4'd15;
  localparam logic [3:0] PatStraight = 4'd9;

  // configuration
  logic [7:0] right_angle_q, large_q, recover_q, small_q, limit_q;
  logic [9:0] base_q;

  // tracking state
  logic              running_q, running_d;
  logic              finish_q, finish_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [ArmW-1:0]   arm_q, arm_d;
  logic [CrossW-1:0] cross_q, cross_d;
  logic [3:0]        last_q, last_d;

  // per-word working registers
  logic signed [8:0] turn_q, turn_d;
  logic [7:0]        mag_q, mag_d;
  logic              zero_q, zero_d;
  logic              bzero_q, bzero_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [7:0]        rem_q, rem_d;
  logic [17:0]       prod;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  function automatic logic signed [8:0] turn_for(input logic [3:0] pat, input logic [3:0] prev,
                                                 input logic [7:0] ra, input logic [7:0] lg,
                                                 input logic [7:0] rc, input logic [7:0] sm);
    logic signed [8:0] t;
    t = '0;
    unique case (pat)
      PatR1, PatR2:       t = $signed({1'b0, ra});
      PatL1, PatL2:       t = -$signed({1'b0, ra});
      PatLargeR:          t = $signed({1'b0, lg});
      PatLargeL:          t = -$signed({1'b0, lg});
      PatSmallR:          t = $signed({1'b0, sm});
      PatSmallL:          t = -$signed({1'b0, sm});
      PatLost: begin
        priority if (prev == PatSmallR) t = $signed({1'b0, rc});
        else if (prev == PatSmallL)     t = -$signed({1'b0, rc});
        else if (prev == PatLargeR)     t = $signed({1'b0, lg});
        else if (prev == PatLargeL)     t = -$signed({1'b0, lg});
        else                            t = '0;
      end
      default:            t = '0;
    endcase
    return t;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_angle_q <= RstRightAngle;
      large_q       <= RstLarge;
      recover_q     <= RstRecover;
      small_q       <= RstSmall;
      base_q        <= RstBase;
      limit_q       <= RstLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRightAngle: right_angle_q <= cfg_wdata_i[7:0];
        CfgLarge:      large_q       <= cfg_wdata_i[7:0];
        CfgRecover:    recover_q     <= cfg_wdata_i[7:0];
        CfgSmall:      small_q       <= cfg_wdata_i[7:0];
        CfgBase:       base_q        <= cfg_wdata_i;
        CfgLimit:      limit_q       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // tick update, evaluated on the accepted word
  always_comb begin
    logic run_s;
    logic [ArmW-1:0] arm_n;
    logic [CrossW-1:0] cross_n;
    logic signed [8:0] t;
    run_s     = running_q | start_req_i;
    running_d = run_s;
    finish_d  = start_req_i ? 1'b0 : finish_q;
    ticks_d   = ticks_q;
    arm_d     = '0;
    cross_d   = '0;
    last_d    = last_q;
    zero_d    = 1'b1;
    arm_n     = arm_q;
    cross_n   = cross_q;
    t = turn_for(sensor_bits_i, last_q, right_angle_q, large_q, recover_q, small_q);
    if (run_s) begin
      ticks_d = ticks_q + 1'b1;
      if (arm_q < ArmMax) arm_n = arm_q + 1'b1;
      arm_d   = arm_n;
      cross_d = cross_q;
      zero_d  = 1'b0;
      if (arm_n >= ArmMax) begin
        if (sensor_bits_i == PatCross) begin
          if (cross_q < CrossMax) cross_n = cross_q + 1'b1;
          cross_d = cross_n;
          if (cross_n > HoldMax) begin
            running_d = 1'b0;
            finish_d  = 1'b1;
            arm_d     = '0;
            cross_d   = '0;
            zero_d    = 1'b1;
          end
        end else begin
          cross_d = '0;
        end
      end
      if (!zero_d && sensor_bits_i != PatLost) last_d = sensor_bits_i;
    end
    turn_d  = zero_d ? '0 : t;
    mag_d   = turn_d[8] ? 8'(-turn_d) : turn_d[7:0];
    bzero_d = zero_d | (limit_q == 8'd0) | (mag_d >= limit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      finish_q  <= 1'b0;
      ticks_q   <= '0;
      arm_q     <= '0;
      cross_q   <= '0;
      last_q    <= PatStraight;
    end else if (cmd_i.load) begin
      running_q <= running_d;
      finish_q  <= finish_d;
      ticks_q   <= ticks_d;
      arm_q     <= arm_d;
      cross_q   <= cross_d;
      last_q    <= last_d;
    end
  end

  assign prod = {8'b0, base_q} * {10'b0, 8'(limit_q - mag_q)};

  // restoring divide, two quotient bits a cycle, quotient shifts into num_q
  always_comb begin
    logic [7:0] r;
    logic [NumW-1:0] n;
    logic [8:0] t;
    r = rem_q;
    n = num_q;
    for (int i = 0; i < 2; i++) begin
      t = {r, n[NumW-1]};
      if (t >= {1'b0, limit_q}) begin
        r = 8'(t - {1'b0, limit_q});
        n = {n[NumW-2:0], 1'b1};
      end else begin
        r = t[7:0];
        n = {n[NumW-2:0], 1'b0};
      end
    end
    rem_d = r;
    num_d = n;
  end

  always_comb begin
    logic [QuotW-1:0] bq;
    logic [TargetW-1:0] bw, tw, left, right;
    bq    = bzero_q ? '0 : num_q[QuotW-1:0];
    bw    = {2'b0, bq};
    tw    = {{3{turn_q[8]}}, turn_q, 8'b0};
    left  = zero_q ? '0 : bw - tw;
    right = zero_q ? '0 : bw + tw;
    out_data_d = {6'b0, ticks_q, finish_q, running_q, right, left};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      turn_q  <= turn_d;
      mag_q   <= mag_d;
      zero_q  <= zero_d;
      bzero_q <= bzero_d;
    end
    if (cmd_i.mul) begin
      num_q <= {prod, 8'b0};
      rem_q <= '0;
    end else if (cmd_i.step) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

>>> hw/rtl/line_follower_steering_unit.sv
// Top level of the line follower steering unit: controller plus datapath.
// Depends on lfs_pkg, lfs_ctrl and lfs_dp.
`timescale 1ns / 1ps

// One input word per millisecond tick gives one output word with both wheel targets
// (mm/s, 8 fraction bits), the run and finish flags and the run tick count. A word is
// accepted, passes the speed multiply and the two-bit-a-cycle divider that scales the
// cruise speed by the forward limit, and is loaded into the output register once it
// is free; no new word is taken before that load. The result may wait in the output
// register while the next word is already being worked on. Start in a word takes
// effect on that same tick. Configuration must be written by the plain write port
// only while idle; the unit does not enforce it, and ignores writes to unused indexes.
module line_follower_steering_unit #(
  parameter int unsigned ARM_DELAY_TICKS  = 800,
  parameter int unsigned CROSS_HOLD_TICKS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] sensor_bits, [4] start_req, [7:5] zero
  input  logic [lfs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [19:0] left_target, [39:20] right_target, [40] is_running, [41] finished,
  // [73:42] elapsed_ms, [79:74] zero
  output logic [lfs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lfs_pkg::*;

  lfs_cmd_t cmd;
  lfs_sts_t sts;

  lfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfs_dp #(
    .ARM_DELAY_TICKS  (ARM_DELAY_TICKS),
    .CROSS_HOLD_TICKS (CROSS_HOLD_TICKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sensor_bits_i (s_axis_tdata[SensorW-1:0]),
    .start_req_i   (s_axis_tdata[SensorW]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

>>> hw/rtl/lfs_chk.sv
// Port-level checks of the line follower steering unit, bound to the top level.
// Depends on lfs_pkg and line_follower_steering_unit.
`timescale 1ns / 1ps

module lfs_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lfs_pkg::OutDataW-1:0] m_axis_tdata
);
  import lfs_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[40] |-> m_axis_tdata[39:0] == '0)
    else $error("wheel target non-zero while stopped");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[40] && m_axis_tdata[41]))
    else $error("running and finished both set");

endmodule

bind line_follower_steering_unit lfs_chk u_lfs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> test/tb_line_follower_steering_unit.sv
// Self-checking testbench for line_follower_steering_unit: a queue-fed stream driver,
// a result monitor and a tick-by-tick steering predictor held in step with the unit.
// Depends on lfs_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_line_follower_steering_unit;

  import lfs_pkg::*;

  localparam int ArmTicks  = 800;
  localparam int HoldTicks = 20;
  localparam int CrossSat  = 31;
  localparam int CycleLimit = 600000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd6;

  localparam logic [3:0] PatCross     = 4'b0000;
  localparam logic [3:0] PatCornerPos = 4'b0001;
  localparam logic [3:0] PatCornerPs2 = 4'b0011;
  localparam logic [3:0] PatCornerNeg = 4'b1000;
  localparam logic [3:0] PatCornerNg2 = 4'b1100;
  localparam logic [3:0] PatWidePos   = 4'b0111;
  localparam logic [3:0] PatWideNeg   = 4'b1110;
  localparam logic [3:0] PatSlightPos = 4'b1011;
  localparam logic [3:0] PatSlightNeg = 4'b1101;
  localparam logic [3:0] PatStraight  = 4'b1001;
  localparam logic [3:0] PatLost      = 4'b1111;

  // same layout as m_axis_tdata[73:0]
  typedef struct packed {
    logic [31:0] ticks;
    logic        fin;
    logic        run;
    logic [19:0] right;
    logic [19:0] left;
  } wheel_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [InDataW-1:0] tick_queue[$];
  wheel_cmd_t wheel_queue[$];

  int unsigned src_pct = 0;
  int unsigned snk_pct = 0;
  logic hold_src = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  logic got_v = 1'b0;
  wheel_cmd_t got_word = '0;
  int err_count = 0;
  int cycle_count = 0;

  // predictor state and register copies
  logic        p_running = 1'b0;
  logic        p_finished = 1'b0;
  logic [31:0] p_ticks = '0;
  int          p_arm = 0;
  int          p_cross = 0;
  logic [3:0]  p_last = PatStraight;
  int g_right = 80, g_large = 65, g_recover = 40, g_small = 15, g_base = 250, g_limit = 50;

  line_follower_steering_unit #(
    .ARM_DELAY_TICKS (ArmTicks),
    .CROSS_HOLD_TICKS(HoldTicks)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [3:0] sensor_bits, [4] start_req
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // left, right, is_running, finished, elapsed_ms
  );

  always #10 clk_i = ~clk_i;

  function automatic wheel_cmd_t steer_tick(input logic [3:0] pat, input logic start);
    wheel_cmd_t r;
    int turn;
    int mag;
    int base_q;
    int lv;
    int rv;
    logic stop;
    r = '0;
    stop = 1'b0;
    if (start) begin
      p_running = 1'b1;
      p_finished = 1'b0;
    end
    if (!p_running) begin
      p_arm = 0;
      p_cross = 0;
    end else begin
      p_ticks = p_ticks + 32'd1;
      if (p_arm < ArmTicks) p_arm++;
      if (p_arm >= ArmTicks) begin
        if (pat == PatCross) begin
          if (p_cross < CrossSat) p_cross++;
          if (p_cross > HoldTicks) begin
            p_running = 1'b0;
            p_finished = 1'b1;
            p_arm = 0;
            p_cross = 0;
            stop = 1'b1;
          end
        end else begin
          p_cross = 0;
        end
      end
      if (!stop) begin
        case (pat)
          PatCornerPos, PatCornerPs2: turn = g_right;
          PatCornerNeg, PatCornerNg2: turn = -g_right;
          PatWidePos:   turn = g_large;
          PatWideNeg:   turn = -g_large;
          PatSlightPos: turn = g_small;
          PatSlightNeg: turn = -g_small;
          PatLost: begin
            // line lost: steer on from the last pattern seen
            case (p_last)
              PatSlightPos: turn = g_recover;
              PatSlightNeg: turn = -g_recover;
              PatWidePos:   turn = g_large;
              PatWideNeg:   turn = -g_large;
              default:      turn = 0;
            endcase
          end
          default: turn = 0;
        endcase
        if (pat != PatLost) p_last = pat;
        mag = (turn < 0) ? -turn : turn;
        if (g_limit != 0 && mag < g_limit) begin
          base_q = (256 * g_base * (g_limit - mag)) / g_limit;
        end else begin
          base_q = 0;
        end
        lv = base_q - 256 * turn;
        rv = base_q + 256 * turn;
        r.left = lv[19:0];
        r.right = rv[19:0];
      end
    end
    r.run = p_running;
    r.fin = p_finished;
    r.ticks = p_ticks;
    return r;
  endfunction

  function automatic logic [3:0] line_pattern();
    case ($urandom_range(0, 8))
      0: return PatStraight;
      1: return PatSlightPos;
      2: return PatSlightNeg;
      3: return PatWidePos;
      4: return PatWideNeg;
      5: return PatCornerPos;
      6: return PatCornerPs2;
      7: return PatCornerNeg;
      default: return PatCornerNg2;
    endcase
  endfunction

  task automatic push_tick(input logic [3:0] pat, input logic start);
    tick_queue.push_back({3'b000, start, pat});
  endtask

  // mostly tracked line with random content, crossing bursts around the hold count
  task automatic push_run(input int n);
    int k;
    int burst;
    int roll;
    logic restart;
    k = 0;
    restart = 1'b0;
    while (k < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        burst = $urandom_range(1, 26);
        repeat (burst) push_tick(PatCross, 1'b0);
        k += burst;
        restart = (burst > HoldTicks) && ($urandom_range(0, 9) < 7);
      end else begin
        if (roll < 75) push_tick(line_pattern(), restart || ($urandom_range(0, 99) == 0));
        else if (roll < 90) push_tick(PatLost, restart);
        else push_tick(4'($urandom_range(0, 15)), restart || ($urandom_range(0, 3) == 0));
        restart = 1'b0;
        k++;
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CfgDataW-1:0];
    case (idx)
      CfgRightAngle: g_right = value & 8'hFF;
      CfgLarge:      g_large = value & 8'hFF;
      CfgRecover:    g_recover = value & 8'hFF;
      CfgSmall:      g_small = value & 8'hFF;
      CfgBase:       g_base = value & 10'h3FF;
      CfgLimit:      g_limit = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_gains(input int ra, input int lg, input int rc, input int sm,
                           input int bs, input int lim);
    write_reg(CfgRightAngle, ra);
    write_reg(CfgLarge, lg);
    write_reg(CfgRecover, rc);
    write_reg(CfgSmall, sm);
    write_reg(CfgBase, bs);
    write_reg(CfgLimit, lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || s_axis_tvalid || wheel_queue.size() != 0 || got_v);
  endtask

  always @(posedge clk_i) begin : drive_ticks
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        wheel_queue.push_back(steer_tick(s_axis_tdata[3:0], s_axis_tdata[4]));
        void'(tick_queue.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < src_pct) begin
        gap_left <= $urandom_range(0, 16);
        s_axis_tvalid <= 1'b0;
      end else if (!hold_src && tick_queue.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tick_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : sink_results
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      got_v <= 1'b0;
    end else begin
      got_v <= m_axis_tvalid && m_axis_tready;
      got_word <= m_axis_tdata[73:0];
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_pct) begin
        stall_left <= $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare on the falling edge after the handshake, once the driver has predicted
  always @(negedge clk_i) begin : check_results
    wheel_cmd_t want;
    if (got_v) begin
      if (wheel_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("result word with nothing expected: %h", got_word);
      end else begin
        want = wheel_queue.pop_front();
        if (want !== got_word) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch exp: L=%0d R=%0d run=%0b fin=%0b ms=%0d",
                     $signed(want.left), $signed(want.right), want.run, want.fin,
                     want.ticks);
            $display("         got: L=%0d R=%0d run=%0b fin=%0b ms=%0d",
                     $signed(got_word.left), $signed(got_word.right), got_word.run,
                     got_word.fin, got_word.ticks);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_line_follower_steering_unit: errors");
    $finish;
  end

  initial begin : run_test
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset register values
    src_pct = 15;
    snk_pct = 15;
    push_tick(PatLost, 1'b0);
    push_tick(PatCross, 1'b0);
    push_tick(PatStraight, 1'b1);
    for (int p = 0; p < 16; p++) push_tick(p[3:0], 1'b0);
    push_tick(PatSlightPos, 1'b0);
    push_tick(PatLost, 1'b0);
    push_tick(PatSlightNeg, 1'b0);
    push_tick(PatLost, 1'b0);
    push_tick(PatWidePos, 1'b0);
    push_tick(PatLost, 1'b0);
    push_tick(4'b0110, 1'b1);
    drain();

    // low extremes
    set_gains(0, 0, 0, 0, 0, 1);
    src_pct = 30;
    snk_pct = 30;
    push_tick(PatStraight, 1'b1);
    push_run(150);
    drain();

    // high extremes, long enough to arm, with a sender hold-off part way
    set_gains(255, 255, 255, 255, 1023, 255);
    src_pct = 10;
    snk_pct = 40;
    push_run(850);
    repeat (22) push_tick(PatCross, 1'b0);
    push_tick(PatStraight, 1'b0);
    do @(negedge clk_i); while (tick_queue.size() > 500);
    hold_src = 1'b1;
    do @(negedge clk_i); while (s_axis_tvalid || wheel_queue.size() != 0 || got_v);
    hold_src = 1'b0;
    drain();

    // forward limit zero: no cruise term at all
    set_gains($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 1023), 0);
    src_pct = 20;
    snk_pct = 5;
    push_tick(PatSlightPos, 1'b1);
    push_run(150);
    drain();

    // random settings, plus a write to an unused index
    set_gains($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(1, 255));
    write_reg(CfgUnused, $urandom_range(0, 1023));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    src_pct = 25;
    snk_pct = 25;
    push_run(200);
    drain();

    // last stretch at full rate
    set_gains($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(1, 255));
    src_pct = 0;
    snk_pct = 0;
    do @(negedge clk_i); while (gap_left != 0 || stall_left != 0);
    push_run(300);
    drain();

    repeat (40) @(posedge clk_i);
    if (err_count == 0 && wheel_queue.size() == 0) begin
      $display("tb_line_follower_steering_unit: clean");
    end else begin
      $display("tb_line_follower_steering_unit: errors");
    end
    $finish;
  end

endmodule
